>>> rtl/core/fpalu_pkg.sv
// Package with command codes, status codes and the queue entry type of the fixed-point ALU.
`default_nettype none
package fpalu_pkg;
  typedef enum logic [3:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_INC = 4'd4,
    CMD_DEC = 4'd5,
    CMD_MIN = 4'd6,
    CMD_MAX = 4'd7,
    CMD_CMP = 4'd8
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  // Classes that the front end sorts commands into.
  typedef enum logic [1:0] {
    CL_SIMPLE = 2'd0,
    CL_MUL    = 2'd1,
    CL_DIV    = 2'd2
  } op_class_t;

  // One classified beat handed from front end to back end.
  typedef struct packed {
    op_class_t   op_class;
    logic [31:0] simple_res;
    status_t     simple_st;
    logic        neg;
    logic        b_zero;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic        less;
    logic        equal;
    logic        greater;
  } entry_t;
endpackage
`default_nettype wire

>>> rtl/core/fpalu_front.sv
// Front end: takes input beats, handles the simple commands and classifies the rest.
`default_nettype none
module fpalu_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [3:0]        in_cmd,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                   fe_valid,
  input  wire logic              fe_ready,
  output fpalu_pkg::entry_t      fe_entry
);
  import fpalu_pkg::*;

  logic   valid_r, valid_nxt;
  entry_t entry_r, entry_nxt;
  logic signed [32:0] sum, dif, inc, dcr;
  logic lt, eq;

  assign in_ready = !valid_r || fe_ready;
  assign fe_valid = valid_r;
  assign fe_entry = entry_r;

  // Compare and short arithmetic.
  always_comb begin
    lt  = in_operand_a < in_operand_b;
    eq  = in_operand_a == in_operand_b;
    sum = 33'(in_operand_a) + 33'(in_operand_b);
    dif = 33'(in_operand_a) - 33'(in_operand_b);
    inc = 33'(in_operand_a) + 33'sd1;
    dcr = 33'(in_operand_a) - 33'sd1;
  end

  function automatic logic [33:0] sat33(input logic signed [32:0] v);
    logic [33:0] r;
    if (v[32] != v[31]) begin
      r = {ST_OVF, v[32] ? 32'h8000_0000 : 32'h7fff_ffff};
    end else begin
      r = {ST_OK, v[31:0]};
    end
    return r;
  endfunction

  // Build the next entry.
  always_comb begin
    logic [33:0] s;
    s = {ST_OK, in_operand_a};
    entry_nxt = '0;
    entry_nxt.op_class = CL_SIMPLE;
    case (in_cmd)
      CMD_ADD: s = sat33(sum);
      CMD_SUB: s = sat33(dif);
      CMD_INC: s = sat33(inc);
      CMD_DEC: s = sat33(dcr);
      CMD_MIN: s = {ST_OK, lt ? in_operand_a : in_operand_b};
      CMD_MAX: s = {ST_OK, (!lt && !eq) ? in_operand_a : in_operand_b};
      CMD_MUL: entry_nxt.op_class = CL_MUL;
      CMD_DIV: entry_nxt.op_class = CL_DIV;
      default: s = {ST_OK, in_operand_a};
    endcase
    entry_nxt.simple_res = s[31:0];
    entry_nxt.simple_st  = status_t'(s[33:32]);
    entry_nxt.neg        = in_operand_a[31] != in_operand_b[31];
    entry_nxt.b_zero     = in_operand_b == 32'sd0;
    entry_nxt.mag_a      = in_operand_a[31] ? 32'(-in_operand_a) : in_operand_a;
    entry_nxt.mag_b      = in_operand_b[31] ? 32'(-in_operand_b) : in_operand_b;
    entry_nxt.less       = lt;
    entry_nxt.equal      = eq;
    entry_nxt.greater    = !lt && !eq;
  end

  always_comb valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (in_ready && in_valid) begin
      entry_r <= entry_nxt;
    end
  end
endmodule
`default_nettype wire

>>> rtl/core/fpalu_queue.sv
// Two-entry queue between the front end and the back end.
`default_nettype none
module fpalu_queue (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_valid,
  output logic                   wr_ready,
  input  wire fpalu_pkg::entry_t wr_entry,
  output logic                   rd_valid,
  input  wire logic              rd_ready,
  output fpalu_pkg::entry_t      rd_entry
);
  import fpalu_pkg::*;

  entry_t mem_r [2];
  logic   wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_entry = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_entry;
  end
endmodule
`default_nettype wire

>>> rtl/core/fpalu_back.sv
// Back end: pipelined multiply and divide with rounding, saturation and the output register.
`default_nettype none
module fpalu_back #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_valid,
  output logic                   q_ready,
  input  wire fpalu_pkg::entry_t q_entry,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [31:0]     out_result,
  output logic                   out_less,
  output logic                   out_equal,
  output logic                   out_greater,
  output logic [1:0]             out_status
);
  import fpalu_pkg::*;

  // Divider: quotient of (mag_a << FRAC_BITS) by mag_b, one bit a stage.
  localparam int unsigned NW  = 32 + FRAC_BITS;
  localparam int unsigned NST = NW + 3;

  typedef struct packed {
    entry_t      e;
    logic [NW-1:0] num;
    logic [32:0] rem;
    logic [63:0] acc;
  } stage_t;

  stage_t st_r [NST+1];
  logic   vl_r [NST+1];
  logic   adv;

  // Whole pipeline moves together; it stalls only when the output holds.
  assign adv     = !vl_r[NST] || out_ready;
  assign q_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= NST; i++) vl_r[i] <= 1'b0;
    end else if (adv) begin
      vl_r[0] <= q_valid;
      for (int i = 1; i <= NST; i++) vl_r[i] <= vl_r[i-1];
    end
  end

  // Stage 0 loads; stage 1 multiplies; stages 2..NW+1 divide; last rounds.
  always_ff @(posedge clk) begin
    if (adv) begin
      st_r[0].e   <= q_entry;
      st_r[0].num <= NW'(q_entry.mag_a) << FRAC_BITS;
      st_r[0].rem <= '0;
      st_r[0].acc <= '0;
      for (int i = 1; i <= NST; i++) begin
        st_r[i] <= st_r[i-1];
      end
      if (st_r[0].e.op_class == CL_MUL) begin
        st_r[1].acc <= 64'(st_r[0].e.mag_a) * 64'(st_r[0].e.mag_b);
      end
      for (int i = 2; i <= NW + 1; i++) begin
        logic [32:0] t;
        t = {st_r[i-1].rem[31:0], st_r[i-1].num[NW-1]};
        st_r[i].num <= st_r[i-1].num << 1;
        if (st_r[i-1].e.op_class == CL_DIV) begin
          if (t >= 33'(st_r[i-1].e.mag_b)) begin
            st_r[i].rem <= t - 33'(st_r[i-1].e.mag_b);
            st_r[i].acc <= {st_r[i-1].acc[62:0], 1'b1};
          end else begin
            st_r[i].rem <= t;
            st_r[i].acc <= {st_r[i-1].acc[62:0], 1'b0};
          end
        end
      end
    end
  end

  // Rounding and saturation on the stage before the output.
  logic [63:0] qv;
  logic [64:0] qr;
  logic [63:0] lim;
  logic [31:0] rs;
  status_t     ss;
  stage_t      f;
  always_comb begin
    f  = st_r[NST-1];
    qv = f.acc;
    if (f.e.op_class == CL_MUL) begin
      if (FRAC_BITS > 0) begin
        qr = (65'(qv) + (65'd1 << FRAC_BITS >> 1)) >> FRAC_BITS;
      end else begin
        qr = 65'(qv);
      end
    end else begin
      qr = 65'(qv) + 65'(f.rem >= 33'(f.e.mag_b) - f.rem);
    end
    lim = f.e.neg ? 64'h8000_0000 : 64'h7fff_ffff;
    rs  = f.e.simple_res;
    ss  = f.e.simple_st;
    case (f.e.op_class)
      CL_MUL, CL_DIV: begin
        if (qr > 65'(lim)) begin
          ss = ST_OVF;
          rs = f.e.neg ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
          ss = ST_OK;
          rs = f.e.neg ? 32'(-qr[31:0]) : qr[31:0];
        end
        if (f.e.op_class == CL_DIV && f.e.b_zero) begin
          ss = ST_DIVZ;
          rs = f.e.mag_a == 32'd0 ? 32'd0 :
               (f.e.neg ? 32'h8000_0000 : 32'h7fff_ffff);
        end
      end
      default: ;
    endcase
  end

  logic [31:0] res_r;
  status_t     sts_r;
  logic        lt_r, eq_r, gt_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= rs;
      sts_r <= ss;
      lt_r  <= f.e.less;
      eq_r  <= f.e.equal;
      gt_r  <= f.e.greater;
    end
  end

  assign out_valid   = vl_r[NST];
  assign out_result  = res_r;
  assign out_status  = sts_r;
  assign out_less    = lt_r;
  assign out_equal   = eq_r;
  assign out_greater = gt_r;
endmodule
`default_nettype wire

>>> rtl/core/fixed_point_alu.sv
// Top level of the fixed-point ALU: front end, queue and back end.
//
//  channel | ports                                | direction
//  in      | in_valid/in_ready, cmd, operand_a/b  | to block
//  out     | out_valid/out_ready, result, flags   | from block
//
// One beat is accepted per cycle while the output does not stall; all commands
// pass through the one-bit-per-stage divider pipeline.
// Reset empties the front register, the queue and the pipeline.
// A stall at the output holds the whole back end; the queue and front
// register absorb up to three more beats before in_ready falls.
`default_nettype none
module fixed_point_alu #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_cmd,
  input  wire logic signed [31:0] in_operand_a,
  input  wire logic signed [31:0] in_operand_b,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_result,
  output logic                    out_less,
  output logic                    out_equal,
  output logic                    out_greater,
  output logic [1:0]              out_status
);
  import fpalu_pkg::*;

  logic   fe_valid, fe_ready, q_valid, q_ready;
  entry_t fe_entry, q_entry;

  fpalu_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_cmd, .in_operand_a, .in_operand_b,
    .fe_valid, .fe_ready, .fe_entry
  );

  fpalu_queue u_queue (
    .clk, .rst_n,
    .wr_valid(fe_valid), .wr_ready(fe_ready), .wr_entry(fe_entry),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_entry(q_entry)
  );

  fpalu_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_entry,
    .out_valid, .out_ready, .out_result, .out_less, .out_equal, .out_greater,
    .out_status
  );
endmodule
`default_nettype wire

>>> rtl/core/fpalu_checker.sv
// Port-level checker for the fixed-point ALU and its bind.
`default_nettype none
module fpalu_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_less,
  input wire logic        out_equal,
  input wire logic        out_greater,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_result
);
  import fpalu_pkg::*;

  a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot({out_less, out_equal, out_greater}))
    else $error("flags not one-hot");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 2'(ST_DIVZ))
    else $error("bad status");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("output dropped");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind fixed_point_alu fpalu_checker u_chk (.*);
`default_nettype wire
